>>> hdl/imu_complementary_filter_top_assert.svh
// ---------------------------------------------------------------------------
// imu complementary filter assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef IMU_COMPLEMENTARY_FILTER_TOP_ASSERT_SVH
`define IMU_COMPLEMENTARY_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define ICF_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icf assertion failed");

// next-cycle implication
`define ICF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icf assertion failed");

`endif

>>> hdl/icf_pkg.sv
// ---------------------------------------------------------------------------
// icf_pkg
// types, constants and tables of the imu complementary filter
// ---------------------------------------------------------------------------
`default_nettype none
package icf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int OPW              = 26;
  localparam int XW               = 43;
  localparam int ZW               = 26;
  localparam int SQW              = 48;
  localparam int RTW              = 24;
  localparam int CFG_IDX_W        = 2;

  localparam logic [15:0] BLEND_RESET = 16'd32113;
  localparam logic [15:0] GYRO_RESET  = 16'd10230;
  localparam logic signed [ZW-1:0] HALF_TURN = 26'sd11796480;

  localparam logic [CFG_IDX_W-1:0] CFG_BLEND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO  = 2'd1;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;
    logic signed [31:0] angle_z;
  } out_item_t;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_RSTART, ST_ROOT, ST_FEED0, ST_FEED1, ST_CWAIT,
    ST_BGYR, ST_BSUM, ST_BMW, ST_BMT, ST_BACC, ST_DONE
  } state_t;

  function automatic logic signed [ZW-1:0] icf_atan(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = 26'sd2949120;
      1:       v = 26'sd1740967;
      2:       v = 26'sd919879;
      3:       v = 26'sd466945;
      4:       v = 26'sd234379;
      5:       v = 26'sd117304;
      6:       v = 26'sd58666;
      7:       v = 26'sd29335;
      8:       v = 26'sd14668;
      9:       v = 26'sd7334;
      10:      v = 26'sd3667;
      11:      v = 26'sd1833;
      12:      v = 26'sd917;
      13:      v = 26'sd458;
      14:      v = 26'sd229;
      15:      v = 26'sd115;
      16:      v = 26'sd57;
      17:      v = 26'sd29;
      18:      v = 26'sd14;
      19:      v = 26'sd7;
      20:      v = 26'sd4;
      21:      v = 26'sd2;
      22:      v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hdl/icf_cordic_cell.sv
// ---------------------------------------------------------------------------
// icf_cordic_cell
// one registered cordic vectoring iteration with a fixed shift
// ---------------------------------------------------------------------------
`default_nettype none
module icf_cordic_cell import icf_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  wire   clk,
  input  wire   rst_n,
  input  cord_t d_i,
  output cord_t q_o
);

  cord_t q_r, q_nxt;
  logic signed [XW-1:0] xs, ys;

  always_comb begin
    xs = d_i.x >>> SHIFT;
    ys = d_i.y >>> SHIFT;
    q_nxt = d_i;
    if (!d_i.y[XW-1]) begin
      q_nxt.x = d_i.x + ys;
      q_nxt.y = d_i.y - xs;
      q_nxt.z = d_i.z + icf_atan(SHIFT);
    end else begin
      q_nxt.x = d_i.x - ys;
      q_nxt.y = d_i.y + xs;
      q_nxt.z = d_i.z - icf_atan(SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule
`default_nettype wire

>>> hdl/icf_cordic_row.sv
// ---------------------------------------------------------------------------
// icf_cordic_row
// quadrant fold and a chain of cordic cells giving atan2 in degrees
// ---------------------------------------------------------------------------
`default_nettype none
module icf_cordic_row import icf_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   valid_i,
  input  wire signed [OPW-1:0]  y_i,
  input  wire signed [OPW-1:0]  x_i,
  output logic                  valid_o,
  output logic signed [ZW-1:0]  tilt_o
);

  cord_t stage [0:STEPS];
  logic neg;
  logic signed [OPW-1:0] xa, ya;

  always_comb begin
    neg = x_i[OPW-1];
    xa  = neg ? -x_i : x_i;
    ya  = neg ? -y_i : y_i;
    stage[0].valid = valid_i;
    stage[0].zero  = (x_i == '0) && (y_i == '0);
    stage[0].x     = XW'(xa) <<< 16;
    stage[0].y     = XW'(ya) <<< 16;
    if (neg) begin
      stage[0].z = y_i[OPW-1] ? -HALF_TURN : HALF_TURN;
    end else begin
      stage[0].z = '0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    icf_cordic_cell #(.SHIFT(i)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .d_i  (stage[i]),
      .q_o  (stage[i+1])
    );
  end

  assign valid_o = stage[STEPS].valid;
  assign tilt_o  = stage[STEPS].zero ? '0 : stage[STEPS].z;

endmodule
`default_nettype wire

>>> hdl/icf_isqrt.sv
// ---------------------------------------------------------------------------
// icf_isqrt
// bit-serial integer square root, one result bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none
module icf_isqrt import icf_pkg::*; (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start_i,
  input  wire  [SQW-1:0]   n_i,
  output logic             done_o,
  output logic [RTW-1:0]   root_o
);

  logic [SQW-1:0] rem_r, res_r, rem_nxt, res_nxt, bitv, trial;
  logic [4:0] cnt_r;
  logic busy_r, done_r;

  always_comb begin
    bitv  = SQW'(1) << {cnt_r, 1'b0};
    trial = res_r + bitv;
    if (rem_r >= trial) begin
      rem_nxt = rem_r - trial;
      res_nxt = (res_r >> 1) + bitv;
    end else begin
      rem_nxt = rem_r;
      res_nxt = res_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        rem_r  <= n_i;
        res_r  <= '0;
        cnt_r  <= 5'd23;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        res_r <= res_nxt;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_r;
  assign root_o = res_r[RTW-1:0];

endmodule
`default_nettype wire

>>> hdl/imu_complementary_filter_top.sv
// ---------------------------------------------------------------------------
// imu_complementary_filter_top
// accelerometer tilt by cordic, fused with integrated gyro rate per axis
// ---------------------------------------------------------------------------
// in_stall holds off a new item from acceptance until its result is loaded into the output register.
// per item the square root runs once and the cordic chain twice (x tilt, then y tilt),
//   then a blend unit shared by all three axes steps through BGYR, BSUM, BMW, BMT and BACC per axis
// a new item is taken while the previous result still waits at the output
// reset: synchronous, clears angles to zero and loads the default weights
`default_nettype none
module imu_complementary_filter_top import icf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output out_item_t            out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [15:0]           cfg_data
);

  state_t state_r, state_nxt;
  in_item_t item_r;
  logic [15:0] w_r, inc_r;
  logic signed [31:0] fused_r [0:2];
  logic [SQW-1:0] sq_r;
  logic [RTW-1:0] root;
  logic root_done;
  logic row_valid_in, row_valid_out;
  logic signed [OPW-1:0] row_y, row_x;
  logic signed [ZW-1:0] row_tilt, tilt_x_r, tilt_y_r;
  logic got_r;
  logic [RTW-1:0] mag_r;
  logic [1:0] axis_r;
  logic signed [15:0] gyro_sel;
  logic signed [31:0] old_sel;
  logic signed [ZW-1:0] tilt_sel;
  logic signed [32:0] prod_g_r;
  logic signed [33:0] sum_r;
  logic signed [50:0] mw_r;
  logic signed [43:0] mt_r;
  logic signed [17:0] wacc;
  logic signed [51:0] acc;
  logic signed [36:0] sh;
  logic signed [31:0] sat;
  logic out_valid_r;
  out_item_t out_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  icf_isqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start_i(state_r == ST_RSTART),
    .n_i    (sq_r),
    .done_o (root_done),
    .root_o (root)
  );

  always_comb begin
    row_valid_in = (state_r == ST_FEED0) || (state_r == ST_FEED1);
    if (state_r == ST_FEED1) begin
      row_y = -(OPW'(item_r.accel_x) <<< 8);
      row_x = OPW'({1'b0, mag_r});
    end else begin
      row_y = OPW'(item_r.accel_y);
      row_x = OPW'(item_r.accel_z);
    end
  end

  icf_cordic_row #(.STEPS(CORDIC_STEPS)) u_row (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(row_valid_in),
    .y_i    (row_y),
    .x_i    (row_x),
    .valid_o(row_valid_out),
    .tilt_o (row_tilt)
  );

  always_comb begin
    case (axis_r)
      2'd0: begin
        gyro_sel = item_r.gyro_x;
        old_sel  = fused_r[0];
        tilt_sel = tilt_x_r;
      end
      2'd1: begin
        gyro_sel = item_r.gyro_y;
        old_sel  = fused_r[1];
        tilt_sel = tilt_y_r;
      end
      default: begin
        gyro_sel = item_r.gyro_z;
        old_sel  = fused_r[2];
        tilt_sel = '0;
      end
    endcase
    wacc = 18'sd32768 - $signed({2'b00, w_r});
    acc  = 52'(mw_r) + 52'(mt_r) + 52'sd16384;
    sh   = 37'(acc >>> 15);
    if (sh > 37'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (sh < -37'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = sh[31:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SQ;
      ST_SQ:     state_nxt = ST_RSTART;
      ST_RSTART: state_nxt = ST_ROOT;
      ST_ROOT:   if (root_done) state_nxt = ST_FEED0;
      ST_FEED0:  state_nxt = ST_FEED1;
      ST_FEED1:  state_nxt = ST_CWAIT;
      ST_CWAIT:  if (row_valid_out && got_r) state_nxt = ST_BGYR;
      ST_BGYR:   state_nxt = ST_BSUM;
      ST_BSUM:   state_nxt = ST_BMW;
      ST_BMW:    state_nxt = ST_BMT;
      ST_BMT:    state_nxt = ST_BACC;
      ST_BACC:   state_nxt = (axis_r == 2'd2) ? ST_DONE : ST_BGYR;
      ST_DONE:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      w_r         <= BLEND_RESET;
      inc_r       <= GYRO_RESET;
      fused_r[0]  <= '0;
      fused_r[1]  <= '0;
      fused_r[2]  <= '0;
      out_valid_r <= 1'b0;
      got_r       <= 1'b0;
      axis_r      <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BLEND: w_r <= cfg_data;
          CFG_GYRO:  inc_r <= cfg_data;
          default:   ;
        endcase
      end
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) item_r <= in_data;
          got_r  <= 1'b0;
          axis_r <= 2'd0;
        end
        ST_SQ: begin
          sq_r <= SQW'(32'(item_r.accel_y * item_r.accel_y)
                  + 33'(32'(item_r.accel_z * item_r.accel_z))) << 16;
        end
        ST_ROOT:  if (root_done) mag_r <= root;
        ST_CWAIT: begin
          if (row_valid_out) begin
            if (got_r) tilt_y_r <= row_tilt;
            else tilt_x_r <= row_tilt;
            got_r <= 1'b1;
          end
        end
        ST_BGYR:  prod_g_r <= 33'(gyro_sel) * 33'($signed({1'b0, inc_r}));
        ST_BSUM:  sum_r <= 34'(old_sel) + 34'(prod_g_r >>> 8);
        ST_BMW:   mw_r <= 51'($signed({1'b0, w_r})) * 51'(sum_r);
        ST_BMT:   mt_r <= 44'(wacc) * 44'(tilt_sel);
        ST_BACC: begin
          fused_r[axis_r] <= sat;
          axis_r <= axis_r + 2'd1;
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_r.angle_x <= fused_r[0];
            out_r.angle_y <= fused_r[1];
            out_r.angle_z <= fused_r[2];
            out_valid_r   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/icf_checker.sv
// ---------------------------------------------------------------------------
// icf_checker
// port-level checks of the imu complementary filter, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none
`include "imu_complementary_filter_top_assert.svh"
module icf_checker import icf_pkg::*; (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input out_item_t out_data
);

  `ICF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `ICF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `ICF_ASSERT_IMPLIES(a_result_while_busy, $rose(out_valid), $past(in_stall))

endmodule

bind imu_complementary_filter_top icf_checker u_icf_checker (.*);
`default_nettype wire
